// ===== design/nsmt_pkg.sv =====
// ----------------------------------------------------------------------------
// nsmt_pkg
// Shared types and constants of the n-shot modifier tracker.
// ----------------------------------------------------------------------------
package nsmt_pkg;

  // widths fixed by the event and register formats
  localparam int unsigned KeyW     = 16;
  localparam int unsigned ModW     = 8;
  localparam int unsigned CntW     = 5;
  localparam int unsigned LimW     = 4;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned MaxSlots = 8;

  typedef logic [CfgIdxW-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_TRIG_LO   = 3'd0;
  localparam cfg_idx_t CFG_TRIG_HI   = 3'd1;
  localparam cfg_idx_t CFG_MASKS     = 3'd2;
  localparam cfg_idx_t CFG_ALT_MASKS = 3'd3;
  localparam cfg_idx_t CFG_LIMITS    = 3'd4;
  localparam cfg_idx_t CFG_ROLL      = 3'd5;

  // reset values
  localparam logic [31:0]     LimitsRst = 32'h1111_1111;
  localparam logic [ModW-1:0] RollRst   = 8'hFF;

  // slot phase: key up or down, queued or used
  typedef enum logic [1:0] {
    PH_UP_UNQ    = 2'd0,
    PH_UP_Q      = 2'd1,
    PH_DN_UNUSED = 2'd2,
    PH_DN_USED   = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e          phase;
    logic [CntW-1:0] count;
    logic            had_press;
  } slot_st_t;

  // effect of one slot on the modifier byte
  typedef struct packed {
    logic set;
    logic clr;
  } slot_op_t;

endpackage

// ===== design/nsmt_if.sv =====
// ----------------------------------------------------------------------------
// nsmt_if
// Valid/ready channels for key event requests and modifier results.
// ----------------------------------------------------------------------------
interface nsmt_evt_if;
  logic        valid;
  logic        ready;
  logic [15:0] key_code;
  logic        pressed;
  logic        alt_sel;
  logic        is_cancel;
  logic        is_ignored;

  modport source (
    output valid, key_code, pressed, alt_sel, is_cancel, is_ignored,
    input  ready
  );
  modport sink (
    input  valid, key_code, pressed, alt_sel, is_cancel, is_ignored,
    output ready
  );
endinterface

interface nsmt_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] active_mods;

  modport source (output valid, active_mods, input ready);
  modport sink (input valid, active_mods, output ready);
endinterface

// ===== design/nsmt_slot.sv =====
// ----------------------------------------------------------------------------
// nsmt_slot
// Next state of one n-shot slot and its effect on the modifier byte.
// ----------------------------------------------------------------------------
module nsmt_slot (
  input  nsmt_pkg::slot_st_t     st_i,
  input  logic                   match_i,
  input  logic                   pressed_i,
  input  logic                   is_cancel_i,
  input  logic                   is_ignored_i,
  input  logic [3:0]             limit_i,
  input  logic                   roll_i,
  output nsmt_pkg::slot_st_t     st_o,
  output nsmt_pkg::slot_op_t     op_o
);
  import nsmt_pkg::*;

  logic [CntW-1:0] target;
  phase_e          ph;
  logic [CntW-1:0] cnt;
  logic            had;
  slot_op_t        op;

  assign target = {1'b0, limit_i} << 1;

  always_comb begin
    ph  = st_i.phase;
    cnt = st_i.count;
    had = st_i.had_press;
    op  = '0;
    if (match_i) begin
      // trigger key: arm on press, queue or drop on release
      if (pressed_i) begin
        op.set = (ph == PH_UP_UNQ);
        ph     = PH_DN_UNUSED;
        cnt    = '0;
        had    = roll_i;
      end else if (ph == PH_DN_UNUSED) begin
        ph = PH_UP_Q;
      end else if (ph == PH_DN_USED) begin
        ph     = PH_UP_UNQ;
        op.clr = 1'b1;
      end
    end else if (pressed_i) begin
      // other key press: cancel, count a shot, or mark the mod used
      if (is_cancel_i && ph != PH_UP_UNQ) begin
        ph     = PH_UP_UNQ;
        cnt    = '0;
        had    = roll_i;
        op.clr = 1'b1;
      end else if (ph == PH_UP_Q && !is_ignored_i) begin
        cnt = cnt + 5'd1;
        had = 1'b1;
        if (cnt == target) begin
          ph     = PH_UP_UNQ;
          cnt    = '0;
          had    = roll_i;
          op.clr = 1'b1;
        end
      end else if (ph == PH_DN_UNUSED) begin
        had = 1'b1;
      end
    end else if (!is_ignored_i) begin
      // other key release
      if (ph == PH_DN_UNUSED) begin
        if (had) begin
          ph = PH_DN_USED;
        end
      end else if (ph == PH_UP_Q) begin
        if (had) begin
          cnt = cnt + 5'd1;
        end
        if (cnt == target) begin
          ph     = PH_UP_UNQ;
          cnt    = '0;
          had    = roll_i;
          op.clr = 1'b1;
        end
      end
    end
    st_o = '{phase: ph, count: cnt, had_press: had};
    op_o = op;
  end

endmodule

// ===== design/nshot_modifier_tracker.sv =====
// ----------------------------------------------------------------------------
// nshot_modifier_tracker
// Tracks n-shot modifier slots over key events and reports the modifier byte.
// ----------------------------------------------------------------------------
// path: an accepted request goes through the event register, then the result register, to res_o
// throughput: one request per cycle, set by the event register feeding the
//   slot logic and the result register; a stalled result holds the event
//   register, which then blocks further requests
// reset: slots up and unqueued, modifier byte zero, limits one, roll all on
module nshot_modifier_tracker #(
  parameter int unsigned SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  nsmt_evt_if.sink                      evt_i,
  nsmt_res_if.source                    res_o,
  input  logic                          cfg_we_i,
  input  nsmt_pkg::cfg_idx_t            cfg_idx_i,
  input  logic [nsmt_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import nsmt_pkg::*;

  // configuration registers
  logic [63:0]     trig_lo_q, trig_hi_q, masks_q, alt_masks_q;
  logic [31:0]     limits_q;
  logic [ModW-1:0] roll_q;

  // event register
  logic            evt_valid_q;
  logic [KeyW-1:0] key_q;
  logic            pressed_q, alt_q, cancel_q, ignored_q;

  // result register
  logic            res_valid_q;
  logic [ModW-1:0] res_mods_q;

  // tracker state
  slot_st_t        slot_q [SLOTS];
  slot_st_t        slot_d [SLOTS];
  slot_op_t        op     [SLOTS];
  logic [ModW-1:0] mask   [SLOTS];
  logic [ModW-1:0] held_q, held_d;

  logic advance;

  assign advance     = evt_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !evt_valid_q || advance;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_lo_q   <= '0;
      trig_hi_q   <= '0;
      masks_q     <= '0;
      alt_masks_q <= '0;
      limits_q    <= LimitsRst;
      roll_q      <= RollRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TRIG_LO:   trig_lo_q   <= cfg_wdata_i;
        CFG_TRIG_HI:   trig_hi_q   <= cfg_wdata_i;
        CFG_MASKS:     masks_q     <= cfg_wdata_i;
        CFG_ALT_MASKS: alt_masks_q <= cfg_wdata_i;
        CFG_LIMITS:    limits_q    <= cfg_wdata_i[31:0];
        CFG_ROLL:      roll_q      <= cfg_wdata_i[ModW-1:0];
        default: ;
      endcase
    end
  end

  // event register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      evt_valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      key_q     <= evt_i.key_code;
      pressed_q <= evt_i.pressed;
      alt_q     <= evt_i.alt_sel;
      cancel_q  <= evt_i.is_cancel;
      ignored_q <= evt_i.is_ignored;
    end
  end

  // per-slot update
  for (genvar i = 0; i < SLOTS; i++) begin : g_slot
    logic [KeyW-1:0] trig;
    if (i < 4) begin : g_lo
      assign trig = trig_lo_q[KeyW*i +: KeyW];
    end else begin : g_hi
      assign trig = trig_hi_q[KeyW*(i-4) +: KeyW];
    end

    assign mask[i] = alt_q ? alt_masks_q[ModW*i +: ModW] : masks_q[ModW*i +: ModW];

    nsmt_slot u_slot (
      .st_i        (slot_q[i]),
      .match_i     (key_q == trig),
      .pressed_i   (pressed_q),
      .is_cancel_i (cancel_q),
      .is_ignored_i(ignored_q),
      .limit_i     (limits_q[LimW*i +: LimW]),
      .roll_i      (roll_q[i]),
      .st_o        (slot_d[i]),
      .op_o        (op[i])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        slot_q[i] <= '{phase: PH_UP_UNQ, count: '0, had_press: 1'b0};
      end else if (advance) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  // slots act on the modifier byte in index order
  always_comb begin
    held_d = held_q;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (op[i].set) begin
        held_d = held_d | mask[i];
      end
      if (op[i].clr) begin
        held_d = held_d & ~mask[i];
      end
    end
  end

  // modifier byte and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        held_q <= held_d;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_mods_q <= held_d;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.active_mods = res_mods_q;

endmodule

// ===== design/nsmt_checker.sv =====
// ----------------------------------------------------------------------------
// nsmt_checker
// Port-level checks of the n-shot modifier tracker, bound to the top level.
// ----------------------------------------------------------------------------
module nsmt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       evt_valid_i,
  input logic       evt_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic [7:0] res_mods_i
);

  logic       evt_acc, res_acc;
  logic [1:0] pend_q;

  assign evt_acc = evt_valid_i && evt_ready_i;
  assign res_acc = res_valid_i && res_ready_i;

  // requests accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {1'b0, evt_acc} - {1'b0, res_acc};
    end
  end

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_mods_i))
    else $error("result changed while stalled");

  // no result without a pending request
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> pend_q != 2'd0)
    else $error("result without request");

  // at most the event and result registers hold requests
  a_pend_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("too many requests in flight");

  // an empty block takes a request
  a_idle_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd0 |-> evt_ready_i)
    else $error("idle block not ready");

endmodule

bind nshot_modifier_tracker nsmt_checker u_nsmt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .evt_valid_i(evt_i.valid),
  .evt_ready_i(evt_i.ready),
  .res_valid_i(res_o.valid),
  .res_ready_i(res_o.ready),
  .res_mods_i (res_o.active_mods)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the n-shot modifier tracker. Key event requests are
// driven over the valid/ready event channel with random gaps. A behavioral
// slot tracker in the bench predicts the modifier byte of every accepted
// request, and each result is checked in order against that prediction.
// Directed cases come first, then random traffic under several register
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nsmt_pkg::*;

  localparam int unsigned SLOTS      = MaxSlots;
  localparam int unsigned CYCLE_CAP  = 600000;
  localparam int unsigned DRAIN_WAIT = 4;

  logic clk = 1'b0;
  logic rst_n;

  logic                cfg_we;
  cfg_idx_t            cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  nsmt_evt_if evt_if ();
  nsmt_res_if res_if ();

  nshot_modifier_tracker #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .evt_i      (evt_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // clock
  always #4 clk = ~clk;

  // bench copy of the register file
  logic [63:0] trig_lo_m, trig_hi_m, masks_m, alt_masks_m;
  logic [31:0] limits_m;
  logic [7:0]  roll_m;

  // bench copy of the slot state
  phase_e          phase_m [SLOTS];
  logic [CntW-1:0] count_m [SLOTS];
  logic            had_m   [SLOTS];
  logic [ModW-1:0] mods_m;

  logic [ModW-1:0] pending_mods[$];
  int unsigned     error_count = 0;
  int unsigned     items_sent  = 0;
  int unsigned     cycle_count = 0;
  bit              no_gaps     = 1'b0;
  bit              no_stalls   = 1'b0;
  int unsigned     stall_left  = 0;

  // gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [15:0] slot_key(int i);
    logic [127:0] all_keys;
    all_keys = {trig_hi_m, trig_lo_m};
    return all_keys[16*i +: 16];
  endfunction

  // release a slot and clear its mask bits
  function automatic void drop_slot(int i, logic [7:0] mask, logic roll);
    phase_m[i] = PH_UP_UNQ;
    count_m[i] = '0;
    had_m[i]   = roll;
    mods_m     = mods_m & ~mask;
  endfunction

  // advance every slot by one key event and return the modifier byte
  function automatic logic [7:0] track_modifiers(logic [15:0] key, logic press,
                                                 logic alt, logic cancel,
                                                 logic ignored);
    logic [CntW-1:0] target;
    logic [7:0]      mask;
    logic            roll;
    for (int i = 0; i < SLOTS; i++) begin
      target = {limits_m[4*i +: 4], 1'b0};
      mask   = alt ? alt_masks_m[8*i +: 8] : masks_m[8*i +: 8];
      roll   = roll_m[i];
      if (key == slot_key(i)) begin
        // own trigger: cancel and ignored flags do not apply
        if (press) begin
          if (phase_m[i] == PH_UP_UNQ) mods_m = mods_m | mask;
          phase_m[i] = PH_DN_UNUSED;
          count_m[i] = '0;
          had_m[i]   = roll;
        end else if (phase_m[i] == PH_DN_UNUSED) begin
          phase_m[i] = PH_UP_Q;
        end else if (phase_m[i] == PH_DN_USED) begin
          phase_m[i] = PH_UP_UNQ;
          mods_m     = mods_m & ~mask;
        end
      end else if (press) begin
        if (cancel && phase_m[i] != PH_UP_UNQ) drop_slot(i, mask, roll);
        if (phase_m[i] == PH_UP_Q && !ignored) begin
          count_m[i] = count_m[i] + 1'b1;
          had_m[i]   = 1'b1;
          if (count_m[i] == target) drop_slot(i, mask, roll);
        end
        if (phase_m[i] == PH_DN_UNUSED) had_m[i] = 1'b1;
      end else if (!ignored) begin
        if (phase_m[i] == PH_DN_UNUSED) begin
          if (had_m[i]) phase_m[i] = PH_DN_USED;
        end else if (phase_m[i] == PH_UP_Q) begin
          if (had_m[i]) count_m[i] = count_m[i] + 1'b1;
          if (count_m[i] == target) drop_slot(i, mask, roll);
        end
      end
    end
    return mods_m;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // run limit
  initial begin
    while (cycle_count < CYCLE_CAP) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // result side ready with random stalls
  always @(posedge clk) begin
    if (stall_left == 0 && !no_stalls && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    res_if.ready <= (stall_left == 0);
    if (stall_left != 0) stall_left--;
    if ($urandom_range(0, 63) == 0) no_stalls = !no_stalls;
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      if (pending_mods.size() == 0) begin
        report_mismatch($sformatf("unexpected result mods=%02h", res_if.active_mods));
      end else if (res_if.active_mods !== pending_mods[0]) begin
        report_mismatch($sformatf("active_mods got %02h want %02h",
                                  res_if.active_mods, pending_mods[0]));
        void'(pending_mods.pop_front());
      end else begin
        void'(pending_mods.pop_front());
      end
    end
  end

  // one key event request, prediction on acceptance
  task automatic send_event(logic [15:0] key, logic press, logic alt,
                            logic cancel, logic ignored);
    int unsigned gap;
    evt_if.valid      <= 1'b1;
    evt_if.key_code   <= key;
    evt_if.pressed    <= press;
    evt_if.alt_sel    <= alt;
    evt_if.is_cancel  <= cancel;
    evt_if.is_ignored <= ignored;
    do @(posedge clk); while (evt_if.ready !== 1'b1);
    pending_mods.push_back(track_modifiers(key, press, alt, cancel, ignored));
    items_sent++;
    gap = no_gaps ? 0 : pick_gap();
    if ($urandom_range(0, 63) == 0) no_gaps = !no_gaps;
    if (gap != 0) begin
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result
  task automatic wait_idle();
    evt_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_mods.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [63:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_TRIG_LO:   trig_lo_m   = data;
      CFG_TRIG_HI:   trig_hi_m   = data;
      CFG_MASKS:     masks_m     = data;
      CFG_ALT_MASKS: alt_masks_m = data;
      CFG_LIMITS:    limits_m    = data[31:0];
      CFG_ROLL:      roll_m      = data[7:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(logic [63:0] trig_lo, logic [63:0] trig_hi,
                            logic [63:0] masks, logic [63:0] alt_masks,
                            logic [31:0] limits, logic [7:0] roll);
    wait_idle();
    write_cfg(CFG_TRIG_LO, trig_lo);
    write_cfg(CFG_TRIG_HI, trig_hi);
    write_cfg(CFG_MASKS, masks);
    write_cfg(CFG_ALT_MASKS, alt_masks);
    write_cfg(CFG_LIMITS, {32'h0, limits});
    write_cfg(CFG_ROLL, {56'h0, roll});
  endtask

  function automatic logic [31:0] rand_limits(int unsigned lo, int unsigned hi);
    logic [31:0] v;
    for (int i = 0; i < 8; i++) v[4*i +: 4] = 4'($urandom_range(lo, hi));
    return v;
  endfunction

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // non-trigger pool, some triggers, some fully random codes
  function automatic logic [15:0] other_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'h0100 + 16'($urandom_range(0, 15));
    if (r < 80) return slot_key($urandom_range(0, SLOTS - 1));
    return 16'($urandom_range(0, 65535));
  endfunction

  // press and release of one key
  task automatic tap_key();
    logic [15:0] key;
    logic        cancel, ignored;
    key     = other_key();
    cancel  = ($urandom_range(0, 9) == 0);
    ignored = ($urandom_range(0, 4) == 0);
    send_event(key, 1'b1, 1'($urandom_range(0, 1)), cancel, ignored);
    send_event(key, 1'b0, 1'($urandom_range(0, 1)), cancel, ignored);
  endtask

  // mostly trigger-then-taps sequences, the rest single random events
  task automatic run_traffic(int unsigned n_items, int unsigned press_pct);
    int unsigned start;
    logic [15:0] trig;
    logic        alt;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(0, 99) < 70) begin
        trig = slot_key($urandom_range(0, SLOTS - 1));
        alt  = 1'($urandom_range(0, 1));
        send_event(trig, 1'b1, alt, 1'b0, 1'b0);
        // roll into the modifier while it is held
        if ($urandom_range(0, 3) == 0) tap_key();
        send_event(trig, 1'b0, ($urandom_range(0, 4) == 0) ? !alt : alt, 1'b0, 1'b0);
        repeat ($urandom_range(1, 4)) tap_key();
      end else begin
        send_event(other_key(), $urandom_range(0, 99) < press_pct,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
      end
    end
  endtask

  // register reset values: every trigger is key zero, masks empty
  task automatic test_reset_state();
    send_event(16'h0000, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1);
    send_event(16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
    send_event(16'hFFFF, 1'b0, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_directed_cases();
    // slot 7 shares its trigger with slot 0 and its mask bits with slots 0 and 1
    set_config({16'h00E3, 16'h00E2, 16'h00E1, 16'h00E0},
               {16'h00E0, 16'h00E6, 16'h00E5, 16'h00E4},
               64'h0340_2010_0804_0201, 64'h0102_0408_1020_4080,
               32'h1111_F021, 8'hAA);
    // duplicate trigger, one shot, shared bits cleared on release
    send_event(16'h00E0, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(16'h00E0, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(16'h0004, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(16'h0004, 1'b0, 1'b0, 1'b0, 1'b0);
    // held as a plain modifier: key used while down
    send_event(16'h00E1, 1'b1, 1'b1, 1'b0, 1'b0);
    send_event(16'h0010, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(16'h0010, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(16'h00E1, 1'b0, 1'b1, 1'b0, 1'b0);
    // zero shot limit: next release frees it
    send_event(16'h00E2, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(16'h00E2, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(16'h0020, 1'b0, 1'b0, 1'b0, 1'b0);
    // ignored keys do not count, cancel frees at once
    send_event(16'h00E3, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(16'h00E3, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(16'h0030, 1'b1, 1'b0, 1'b0, 1'b1);
    send_event(16'h0030, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(16'h0031, 1'b1, 1'b0, 1'b1, 1'b0);
    // mask of the releasing event differs from the registered one
    send_event(16'h00E4, 1'b1, 1'b0, 1'b0, 1'b0);
    send_event(16'h00E4, 1'b0, 1'b0, 1'b0, 1'b0);
    send_event(16'h0040, 1'b1, 1'b1, 1'b0, 1'b0);
    send_event(16'h0040, 1'b0, 1'b1, 1'b0, 1'b0);
    // extreme codes, and a trigger flagged cancel and ignored
    send_event(16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1);
    send_event(16'h0000, 1'b0, 1'b1, 1'b0, 1'b0);
    send_event(16'h00E5, 1'b1, 1'b1, 1'b1, 1'b1);
    send_event(16'hFFFF, 1'b0, 1'b0, 1'b0, 1'b1);
    send_event(16'h00E5, 1'b0, 1'b0, 1'b1, 1'b1);
  endtask

  task automatic test_unique_triggers();
    set_config({16'h0203, 16'h0202, 16'h0201, 16'h0200},
               {16'h0207, 16'h0206, 16'h0205, 16'h0204},
               rand_word(), rand_word(), rand_limits(1, 3), 8'($urandom_range(0, 255)));
    run_traffic(400, 50);
  endtask

  task automatic test_shared_triggers();
    logic [63:0] lo, hi;
    for (int i = 0; i < 4; i++) begin
      lo[16*i +: 16] = 16'h0200 + 16'($urandom_range(0, 2));
      hi[16*i +: 16] = 16'h0200 + 16'($urandom_range(0, 2));
    end
    set_config(lo, hi, rand_word() & 64'h0F0F_0F0F_0F0F_0F0F, rand_word(),
               rand_limits(0, 4), 8'($urandom_range(0, 255)));
    run_traffic(350, 50);
  endtask

  task automatic test_extreme_config();
    set_config('1, '1, '1, '0, '1, 8'h00);
    run_traffic(150, 50);
    set_config('0, '0, '0, '1, LimitsRst, RollRst);
    run_traffic(100, 50);
  endtask

  // presses pile up so the five-bit count wraps
  task automatic test_zero_limits();
    set_config({16'h0203, 16'h0202, 16'h0201, 16'h0200},
               {16'h0207, 16'h0206, 16'h0205, 16'h0204},
               rand_word(), rand_word(), 32'h0, 8'($urandom_range(0, 255)));
    run_traffic(200, 85);
  endtask

  task automatic test_random_config();
    set_config(rand_word(), rand_word(), rand_word(), rand_word(), $urandom,
               8'($urandom_range(0, 255)));
    run_traffic(200, 50);
    // sender holds off until the tracker has drained
    wait_idle();
    run_traffic(200, 50);
  endtask

  initial begin
    rst_n             = 1'b0;
    evt_if.valid      = 1'b0;
    evt_if.key_code   = '0;
    evt_if.pressed    = 1'b0;
    evt_if.alt_sel    = 1'b0;
    evt_if.is_cancel  = 1'b0;
    evt_if.is_ignored = 1'b0;
    res_if.ready      = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_TRIG_LO;
    cfg_wdata         = '0;
    trig_lo_m         = '0;
    trig_hi_m         = '0;
    masks_m           = '0;
    alt_masks_m       = '0;
    limits_m          = LimitsRst;
    roll_m            = RollRst;
    mods_m            = '0;
    for (int i = 0; i < SLOTS; i++) begin
      phase_m[i] = PH_UP_UNQ;
      count_m[i] = '0;
      had_m[i]   = 1'b0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_directed_cases();
    test_unique_triggers();
    test_shared_triggers();
    test_extreme_config();
    test_zero_limits();
    test_random_config();

    wait_idle();
    if (pending_mods.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_mods.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
